### hw/rtl/fbfl_pkg.sv
// Shared types, codes and constants for the fixed block free list allocator.
package fbfl_pkg;

  // Field widths of the request, result and register channels.
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned INDEX_W    = 8;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned OFFSET_W   = 12;
  localparam int unsigned COUNT_W    = 9;
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_BLOCKS_DEF = 256;
  localparam int unsigned PAGE_BYTES_DEF = 4096;

  // Smallest legal block size in bytes.
  localparam logic [SIZE_W-1:0] MIN_BLOCK_BYTES = 13'd16;

  // Register reset values.
  localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RST  = 13'd32;
  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 9'd128;

  // Saturation point of the free count.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'h1FF;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 4'd1;

  // Request operation codes; the fourth code is a no-op.
  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_INIT  = 2'd2
  } mode_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  // Current register settings handed to the controller.
  typedef struct packed {
    logic [SIZE_W-1:0]  blk_bytes;
    logic [COUNT_W-1:0] block_count;
  } cfg_t;

endpackage

### hw/rtl/fbfl_req_if.sv
// Request channel: operation code and block index.
interface fbfl_req_if
  import fbfl_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [INDEX_W-1:0] block_index;

  modport source (output valid, output mode, output block_index, input ready);
  modport sink (input valid, input mode, input block_index, output ready);
endinterface

### hw/rtl/fbfl_rsp_if.sv
// Result channel: status, granted block, its byte offset and the free count.
interface fbfl_rsp_if
  import fbfl_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  granted_index;
  logic [OFFSET_W-1:0] byte_offset;
  logic [COUNT_W-1:0]  blocks_free;

  modport source (
    output valid, output status, output granted_index, output byte_offset,
    output blocks_free, input ready
  );
  modport sink (
    input valid, input status, input granted_index, input byte_offset,
    input blocks_free, output ready
  );
endinterface

### hw/rtl/fbfl_cfg_if.sv
// Register write channel: register index and write data.
interface fbfl_cfg_if
  import fbfl_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/fbfl_link_mem.sv
// Link memory of the free list: one write port, one read port, registered read.
module fbfl_link_mem
  import fbfl_pkg::*;
#(
  parameter int unsigned DEPTH  = MAX_BLOCKS_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  logic [INDEX_W-1:0] wdata,
  input  logic [ADDR_W-1:0]  raddr,
  output logic [INDEX_W-1:0] rdata
);

  logic [INDEX_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/fbfl_ctrl.sv
// Free list controller: head, free count, init sweep and result register.
module fbfl_ctrl
  import fbfl_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int unsigned ADDR_W     = $clog2(MAX_BLOCKS)
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg_q,
  fbfl_req_if.sink           req,
  fbfl_rsp_if.source         rsp,
  output logic               link_we,
  output logic [ADDR_W-1:0]  link_waddr,
  output logic [INDEX_W-1:0] link_wdata,
  output logic [ADDR_W-1:0]  link_raddr,
  input  logic [INDEX_W-1:0] link_rdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_POP,
    S_INIT
  } state_t;

  state_t              state, state_next;
  logic [MODE_W-1:0]   cmd_mode, cmd_mode_next;
  logic [INDEX_W-1:0]  cmd_index, cmd_index_next;
  logic [INDEX_W-1:0]  head, head_next;
  logic [COUNT_W-1:0]  free_total, free_next;
  logic [COUNT_W-1:0]  init_cnt, init_cnt_next;
  logic [OFFSET_W-1:0] prod, prod_next;

  logic                rsp_valid;
  logic [STATUS_W-1:0] rsp_status;
  logic [INDEX_W-1:0]  rsp_granted;
  logic [OFFSET_W-1:0] rsp_offset;
  logic [COUNT_W-1:0]  rsp_free;

  logic                emit;
  logic [STATUS_W-1:0] res_status;
  logic [INDEX_W-1:0]  res_granted;
  logic [OFFSET_W-1:0] res_offset;
  logic [COUNT_W-1:0]  res_free;

  logic                slot_free;
  logic                req_fire;
  logic                start;
  logic [MODE_W-1:0]   use_mode;
  logic [INDEX_W-1:0]  use_index;
  logic [INDEX_W+SIZE_W-1:0] prod_full;
  logic [31:0]         head_wide, index_wide, cnt_wide;
  logic [COUNT_W-1:0]  cnt_inc;

  // Handshake and the operation that starts in this cycle.
  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign slot_free = !rsp_valid || rsp.ready;
  assign use_mode  = (state == S_IDLE) ? req.mode : cmd_mode;
  assign use_index = (state == S_IDLE) ? req.block_index : cmd_index;
  assign start     = ((state == S_IDLE) && req_fire && slot_free) ||
                     ((state == S_WAIT) && slot_free);

  // Offset of the head block; registered before the pop finishes.
  assign prod_full = {{SIZE_W{1'b0}}, head} * {{INDEX_W{1'b0}}, cfg_q.blk_bytes};

  // Memory addresses sized to the link memory depth.
  assign head_wide  = {{(32-INDEX_W){1'b0}}, head};
  assign index_wide = {{(32-INDEX_W){1'b0}}, use_index};
  assign cnt_wide   = {{(32-COUNT_W){1'b0}}, init_cnt};
  assign cnt_inc    = init_cnt + 9'd1;
  assign link_raddr = head_wide[ADDR_W-1:0];

  // Next-state logic.
  always_comb begin
    state_next     = state;
    cmd_mode_next  = cmd_mode;
    cmd_index_next = cmd_index;
    head_next      = head;
    free_next      = free_total;
    init_cnt_next  = init_cnt;
    prod_next      = prod;
    emit           = 1'b0;
    res_status     = STATUS_OK;
    res_granted    = '0;
    res_offset     = '0;
    res_free       = free_total;
    link_we        = 1'b0;
    link_waddr     = index_wide[ADDR_W-1:0];
    link_wdata     = head;

    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          cmd_mode_next  = req.mode;
          cmd_index_next = req.block_index;
          if (!slot_free) begin
            state_next = S_WAIT;
          end
        end
      end
      S_WAIT: begin
      end
      S_POP: begin
        // Link data of the granted block is the new head.
        head_next   = link_rdata;
        free_next   = free_total - 9'd1;
        emit        = 1'b1;
        res_granted = head;
        res_offset  = prod;
        res_free    = free_total - 9'd1;
        state_next  = S_IDLE;
      end
      S_INIT: begin
        // Chain one block per cycle to its successor.
        link_we       = 1'b1;
        link_waddr    = cnt_wide[ADDR_W-1:0];
        link_wdata    = cnt_inc[INDEX_W-1:0];
        init_cnt_next = cnt_inc;
        if (init_cnt == cfg_q.block_count - 9'd1) begin
          head_next  = '0;
          free_next  = cfg_q.block_count;
          emit       = 1'b1;
          res_free   = cfg_q.block_count;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Execute the operation once the result register can take its result.
    if (start) begin
      state_next = S_IDLE;
      unique case (use_mode)
        MODE_ALLOC: begin
          if (free_total == '0) begin
            emit       = 1'b1;
            res_status = STATUS_EMPTY;
          end else begin
            prod_next  = prod_full[OFFSET_W-1:0];
            state_next = S_POP;
          end
        end
        MODE_FREE: begin
          emit = 1'b1;
          if ({1'b0, use_index} >= cfg_q.block_count) begin
            res_status = STATUS_RANGE;
          end else begin
            link_we   = 1'b1;
            head_next = use_index;
            free_next = (free_total == COUNT_MAX) ? free_total : free_total + 9'd1;
            res_free  = free_next;
          end
        end
        MODE_INIT: begin
          init_cnt_next = '0;
          state_next    = S_INIT;
        end
        default: begin
          emit = 1'b1;
        end
      endcase
    end
  end

  // State and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      free_total <= '0;
      init_cnt   <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      free_total <= free_next;
      init_cnt   <= init_cnt_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
    cmd_mode  <= cmd_mode_next;
    cmd_index <= cmd_index_next;
    prod      <= prod_next;
    if (emit) begin
      rsp_status  <= res_status;
      rsp_granted <= res_granted;
      rsp_offset  <= res_offset;
      rsp_free    <= res_free;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_status;
  assign rsp.granted_index = rsp_granted;
  assign rsp.byte_offset   = rsp_offset;
  assign rsp.blocks_free   = rsp_free;

  // A result is only produced when the result register is free.
  assert property (@(posedge clk) disable iff (rst) emit |-> slot_free)
    else $error("result produced while result register is occupied");

  // A pop stage follows only an allocation that started on a nonempty pool.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> ($past(start) && ($past(use_mode) == MODE_ALLOC) &&
                          ($past(free_total) != '0)))
    else $error("pop stage without a started allocation");

  // A pop removes exactly one block from the free count.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |=> (free_total == $past(free_total) - 9'd1))
    else $error("pop did not decrement the free count");

  // The init sweep stays inside the pool.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_INIT) |-> (init_cnt < cfg_q.block_count))
    else $error("init sweep beyond the last block");

endmodule

### hw/rtl/fixed_block_free_list_allocator.sv
// Free, no-op and empty allocate register their result once the result register is free;
// a successful allocate first reads the next head from link memory in the pop state, and
// init writes one link per cycle in the init state; both hold off new requests meanwhile.
// Throughput: one free per cycle while the result side takes results.
// Reset clears control state, head and free count and loads 32-byte blocks, up to 128
// of them; the link memory is not cleared and is written by init and free requests.
module fixed_block_free_list_allocator
  import fbfl_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  fbfl_req_if.sink   req,
  fbfl_rsp_if.source rsp,
  fbfl_cfg_if.sink   cfg
);

  localparam int unsigned ADDR_W = $clog2(MAX_BLOCKS);
  localparam logic [COUNT_W-1:0] COUNT_RST =
    (MAX_BLOCKS < 32'(BLOCK_COUNT_RST)) ? COUNT_W'(MAX_BLOCKS) : BLOCK_COUNT_RST;

  cfg_t               cfg_q;
  logic [SIZE_W-1:0]  size_wr;
  logic [COUNT_W-1:0] count_wr;
  logic               link_we;
  logic [ADDR_W-1:0]  link_waddr;
  logic [INDEX_W-1:0] link_wdata;
  logic [ADDR_W-1:0]  link_raddr;
  logic [INDEX_W-1:0] link_rdata;

  assign cfg.ready = 1'b1;

  // Saturate written values to the legal ranges.
  always_comb begin
    size_wr = cfg.data[SIZE_W-1:0];
    if (size_wr < MIN_BLOCK_BYTES) begin
      size_wr = MIN_BLOCK_BYTES;
    end else if ({{(32-SIZE_W){1'b0}}, size_wr} > PAGE_BYTES) begin
      size_wr = PAGE_BYTES[SIZE_W-1:0];
    end
    count_wr = cfg.data[COUNT_W-1:0];
    if (count_wr == '0) begin
      count_wr = 9'd1;
    end else if ({{(32-COUNT_W){1'b0}}, count_wr} > MAX_BLOCKS) begin
      count_wr = MAX_BLOCKS[COUNT_W-1:0];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.blk_bytes   <= BLOCK_SIZE_RST;
      cfg_q.block_count <= COUNT_RST;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == REG_BLOCK_SIZE) begin
        cfg_q.blk_bytes <= size_wr;
      end else if (cfg.index == REG_BLOCK_COUNT) begin
        cfg_q.block_count <= count_wr;
      end
    end
  end

  fbfl_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .ADDR_W     (ADDR_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_q      (cfg_q),
    .req        (req),
    .rsp        (rsp),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .link_raddr (link_raddr),
    .link_rdata (link_rdata)
  );

  fbfl_link_mem #(
    .DEPTH  (MAX_BLOCKS),
    .ADDR_W (ADDR_W)
  ) u_link_mem (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

endmodule

### dv/fbfl_grant_checker.sv
// Checker for the free list allocator: predicts every result and compares it.
`timescale 1ns / 100ps

module fbfl_grant_checker
  import fbfl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  fbfl_req_if  req,
  fbfl_rsp_if  rsp,
  fbfl_cfg_if  cfg,
  output int   fail_count,
  output int   pending
);

  // One predicted result, laid out in the order of the result channel.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  granted;
    logic [OFFSET_W-1:0] offset;
    logic [COUNT_W-1:0]  free_cnt;
  } grant_t;

  // Shadow copy of the pool and of the two registers.
  logic [INDEX_W-1:0] link_mem [MAX_BLOCKS_DEF];
  logic [INDEX_W-1:0] head;
  logic [COUNT_W-1:0] free_cnt;
  logic [SIZE_W-1:0]  blk_size;
  logic [COUNT_W-1:0] blk_count;

  grant_t due_results [$];
  int     errors = 0;

  // Apply one request to the shadow pool and return the result it must give.
  function automatic grant_t pool_step(input logic [MODE_W-1:0] op,
                                       input logic [INDEX_W-1:0] idx);
    grant_t                    r;
    logic [SIZE_W+INDEX_W-1:0] product;
    int                        i;
    r = '0;
    r.status = STATUS_OK;
    case (op)
      MODE_ALLOC: begin
        if (free_cnt == '0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.granted = head;
          product = head * blk_size;
          r.offset = product[OFFSET_W-1:0];
          head = link_mem[head];
          free_cnt = free_cnt - 1'b1;
        end
      end
      MODE_FREE: begin
        if ({1'b0, idx} >= blk_count) begin
          r.status = STATUS_RANGE;
        end else begin
          link_mem[idx] = head;
          head = idx;
          // Double frees can push the count up; it sticks at its maximum.
          if (free_cnt != COUNT_MAX) free_cnt = free_cnt + 1'b1;
        end
      end
      MODE_INIT: begin
        // Chain the blocks in order; the last link wraps modulo 256 and is never followed.
        for (i = 0; i < blk_count; i++) link_mem[i] = INDEX_W'(i + 1);
        head = '0;
        free_cnt = blk_count;
      end
      default: begin
        // The spare mode code changes nothing.
      end
    endcase
    r.free_cnt = free_cnt;
    return r;
  endfunction

  // Watch all three channels; results are checked before new requests are queued.
  always @(posedge clk) begin : watch
    grant_t             got;
    grant_t             want;
    logic [SIZE_W-1:0]  size_raw;
    logic [COUNT_W-1:0] count_raw;
    if (rst) begin
      foreach (link_mem[j]) link_mem[j] = '0;
      head = '0;
      free_cnt = '0;
      blk_size = BLOCK_SIZE_RST;
      blk_count = BLOCK_COUNT_RST;
      due_results.delete();
    end else begin
      // Compare each accepted result with the oldest prediction.
      if (rsp.valid && rsp.ready) begin
        got = {rsp.status, rsp.granted_index, rsp.byte_offset, rsp.blocks_free};
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result with nothing pending: status %0d granted %0d offset %0d free %0d",
                     $time, got.status, got.granted, got.offset, got.free_cnt);
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch (expected/actual) status %0d/%0d granted %0d/%0d offset %0d/%0d free %0d/%0d",
                       $time, want.status, got.status, want.granted, got.granted,
                       want.offset, got.offset, want.free_cnt, got.free_cnt);
          end
        end
      end

      // Register writes saturate into their legal ranges.
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_BLOCK_SIZE) begin
          size_raw = cfg.data[SIZE_W-1:0];
          if (size_raw < MIN_BLOCK_BYTES) size_raw = MIN_BLOCK_BYTES;
          if (size_raw > SIZE_W'(PAGE_BYTES_DEF)) size_raw = SIZE_W'(PAGE_BYTES_DEF);
          blk_size = size_raw;
        end else if (cfg.index == REG_BLOCK_COUNT) begin
          count_raw = cfg.data[COUNT_W-1:0];
          if (count_raw == '0) count_raw = COUNT_W'(1);
          if (count_raw > COUNT_W'(MAX_BLOCKS_DEF)) count_raw = COUNT_W'(MAX_BLOCKS_DEF);
          blk_count = count_raw;
        end
      end

      if (req.valid && req.ready)
        due_results.push_back(pool_step(req.mode, req.block_index));
    end
    pending <= due_results.size();
    fail_count <= errors;
  end

endmodule

### dv/fixed_block_free_list_allocator_tb.sv
// Top of the allocator testbench: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 100ps

module fixed_block_free_list_allocator_tb;
  import fbfl_pkg::*;

  // Codes that the package leaves unnamed.
  localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 4'd9;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 500;
  localparam int RANDOM_PHASES = 12;

  logic clk;
  logic rst;

  fbfl_req_if req ();
  fbfl_rsp_if rsp ();
  fbfl_cfg_if cfg ();

  int fail_count;
  int pending;
  int cycle_count   = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int burst_left    = 0;
  bit steady_send   = 1'b0;
  int pool_blocks   = 128;
  int n_alloc       = 0;
  int n_free        = 0;
  int n_init        = 0;
  int n_unused      = 0;
  int n_settings    = 0;
  int n_writes      = 0;

  fixed_block_free_list_allocator u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  fbfl_grant_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .cfg        (cfg),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("fixed_block_free_list_allocator_tb: errors");
    $finish;
  end

  // The result side stalls in windows of its own, and holds off for a long stretch on demand.
  initial begin : result_sink
    int window;
    int span;
    int k;
    forever begin
      window = $urandom_range(0, 3);
      span = $urandom_range(8, 64);
      for (k = 0; k < span; k++) begin
        if (hold_requests != hold_served) begin
          rsp.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_served++;
        end else begin
          case (window)
            0:       rsp.ready <= 1'b1;
            1:       rsp.ready <= ($urandom_range(0, 3) != 0);
            2:       rsp.ready <= ($urandom_range(0, 3) == 0);
            default: rsp.ready <= ($urandom_range(0, 1) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Offer one request, with a random gap whenever a burst runs out.
  task automatic issue(input logic [MODE_W-1:0] op, input logic [INDEX_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      gap = (steady_send || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    case (op)
      MODE_ALLOC: n_alloc++;
      MODE_FREE:  n_free++;
      MODE_INIT:  n_init++;
      default:    n_unused++;
    endcase
    req.valid <= 1'b1;
    req.mode <= op;
    req.block_index <= idx;
    do @(posedge clk); while (!req.ready);
  endtask

  // Stop sending and wait until every request has been answered.
  task automatic settle();
    req.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    n_writes++;
    do @(posedge clk); while (!cfg.ready);
    // Track the effective pool size so that most frees land inside the pool.
    if (idx == REG_BLOCK_COUNT) begin
      pool_blocks = int'(data[COUNT_W-1:0]);
      if (pool_blocks == 0) pool_blocks = 1;
      else if (pool_blocks > MAX_BLOCKS_DEF) pool_blocks = MAX_BLOCKS_DEF;
    end
  endtask

  // Registers change only while the block is idle.
  task automatic apply_setting(input logic [CFG_DATA_W-1:0] size_data,
                               input logic [CFG_DATA_W-1:0] count_data,
                               input bit touch_spare);
    settle();
    write_reg(REG_BLOCK_SIZE, size_data);
    write_reg(REG_BLOCK_COUNT, count_data);
    if (touch_spare) write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
    cfg.valid <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  initial begin : stimulus
    int p;
    int i;
    int r;
    int phase_items;
    logic [CFG_DATA_W-1:0] size_data;
    logic [CFG_DATA_W-1:0] count_data;

    rst <= 1'b1;
    req.valid <= 1'b0;
    req.mode <= MODE_ALLOC;
    req.block_index <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= REG_BLOCK_SIZE;
    cfg.data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings, no rebuild yet: empty pool, frees outside the pool, the spare
    // mode, and single free/allocate pairs that only touch links they have written.
    issue(MODE_ALLOC, 8'd0);
    issue(MODE_FREE, 8'd128);
    issue(MODE_FREE, 8'd255);
    issue(MODE_UNUSED, 8'hAA);
    issue(MODE_FREE, 8'd5);
    issue(MODE_ALLOC, 8'd0);
    issue(MODE_FREE, 8'd127);
    issue(MODE_ALLOC, 8'd0);
    issue(MODE_ALLOC, 8'd0);

    // Smallest block size from a low write, largest pool from an oversized write.
    // The full rebuild writes every link, so later pops never read an unwritten one.
    apply_setting(16'd4, 16'hFFFF, 1'b1);
    issue(MODE_INIT, 8'h55);
    issue(MODE_ALLOC, 8'd0);
    issue(MODE_ALLOC, 8'd0);
    issue(MODE_ALLOC, 8'd0);
    issue(MODE_FREE, 8'd255);
    issue(MODE_FREE, 8'd0);
    issue(MODE_ALLOC, 8'd0);
    issue(MODE_ALLOC, 8'd0);
    issue(MODE_FREE, 8'd7);
    issue(MODE_FREE, 8'd7);
    issue(MODE_UNUSED, 8'h00);

    // Largest block size and a single-block pool from a count that masks to zero.
    apply_setting(16'hFFFF, 16'h0200, 1'b0);
    issue(MODE_INIT, 8'hFF);
    issue(MODE_ALLOC, 8'd0);
    issue(MODE_ALLOC, 8'd0);
    issue(MODE_FREE, 8'd1);
    issue(MODE_FREE, 8'd0);
    issue(MODE_ALLOC, 8'd0);

    // Back pressure: the result side holds off while frees keep coming, so the
    // block stalls its input; double frees drive the free count into saturation.
    apply_setting(CFG_DATA_W'($urandom_range(16, 4096)), 16'd256, 1'b0);
    steady_send = 1'b1;
    hold_requests <= hold_requests + 1;
    issue(MODE_INIT, INDEX_W'($urandom_range(0, 255)));
    for (i = 0; i < 300; i++) issue(MODE_FREE, INDEX_W'($urandom_range(0, 255)));
    for (i = 0; i < 200; i++) issue(MODE_ALLOC, INDEX_W'($urandom_range(0, 255)));
    steady_send = 1'b0;

    // Random phases, each under its own register setting.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0:       size_data = 16'd16;
        1:       size_data = 16'd4096;
        2:       size_data = CFG_DATA_W'($urandom_range(0, 15));
        3:       size_data = CFG_DATA_W'($urandom_range(4097, 16'hFFFF));
        default: size_data = CFG_DATA_W'($urandom_range(16, 4096));
      endcase
      case ($urandom_range(0, 6))
        0:       count_data = 16'd1;
        1:       count_data = 16'd256;
        2:       count_data = 16'd0;
        3:       count_data = CFG_DATA_W'($urandom_range(257, 16'hFFFF));
        4:       count_data = CFG_DATA_W'($urandom_range(1, 256));
        default: count_data = CFG_DATA_W'($urandom_range(2, 24));
      endcase
      apply_setting(size_data, count_data, 1'b0);
      // Most phases rebuild; the others keep the old list under the new bounds.
      if ($urandom_range(0, 4) != 0) issue(MODE_INIT, INDEX_W'($urandom_range(0, 255)));
      steady_send = ($urandom_range(0, 4) == 0);
      phase_items = $urandom_range(50, 100);
      for (i = 0; i < phase_items; i++) begin
        r = $urandom_range(0, 99);
        if (r < 42) issue(MODE_ALLOC, INDEX_W'($urandom_range(0, 255)));
        else if (r < 78) issue(MODE_FREE, INDEX_W'($urandom_range(0, pool_blocks - 1)));
        else if (r < 86) issue(MODE_FREE, INDEX_W'($urandom_range(0, 255)));
        else if (r < 93) issue(MODE_UNUSED, INDEX_W'($urandom_range(0, 255)));
        else issue(MODE_INIT, INDEX_W'($urandom_range(0, 255)));
      end
      steady_send = 1'b0;
    end

    settle();
    repeat (16) @(posedge clk);

    $display("Sent %0d requests: %0d allocate, %0d free, %0d rebuild, %0d spare mode.",
             n_alloc + n_free + n_init + n_unused, n_alloc, n_free, n_init, n_unused);
    $display("Used %0d register settings over %0d writes, with one %0d-cycle result hold-off.",
             n_settings, n_writes, HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("fixed_block_free_list_allocator_tb: clean");
    end else begin
      $display("fixed_block_free_list_allocator_tb: errors");
    end
    $finish;
  end

endmodule
